### hdl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, defaults and helpers for the bitmap set/clear/find engine.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int DEF_MAP_BITS  = 65536;
    localparam int DEF_WORD_BITS = 64;
    localparam int DEF_MAX_FOUND = 64;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_TEST  = 2'd2,
        KIND_FIND  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_REM,
        ST_READ,
        ST_EXEC,
        ST_SCAN,
        ST_LOAD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic calc_quot;
        logic calc_rem;
        logic mem_rd;
        logic exec;
        logic find_start;
        logic scan_next;
        logic scan_load;
        logic take;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic  clr_last;
        t_kind kind;
        logic  in_map;
        logic  cnt_zero;
        logic  cur_zero;
        logic  word_last;
        logic  pos_over;
        logic  pend_valid;
        logic  left_one;
        logic  out_free;
    } t_stat;

    // Position of the lowest set bit by halving steps; v must be nonzero.
    function automatic logic [5:0] lowest_set(input logic [63:0] v);
        logic [5:0]  n;
        logic [63:0] t;
        n = 6'd0;
        t = v;
        if (t[31:0] == 32'h0) begin
            n = n + 6'd32;
            t = t >> 32;
        end
        if (t[15:0] == 16'h0) begin
            n = n + 6'd16;
            t = t >> 16;
        end
        if (t[7:0] == 8'h0) begin
            n = n + 6'd8;
            t = t >> 8;
        end
        if (t[3:0] == 4'h0) begin
            n = n + 6'd4;
            t = t >> 4;
        end
        if (t[1:0] == 2'h0) begin
            n = n + 6'd2;
            t = t >> 2;
        end
        if (t[0] == 1'b0) begin
            n = n + 6'd1;
        end
        return n;
    endfunction

endpackage

### hdl/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer: clearing pass, index decode, word access and find walk.
// ----------------------------------------------------------------------------
module bsc_ctrl import bsc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_QUOT;
            end
            ST_QUOT: n_state = ST_REM;
            ST_REM:  n_state = ST_READ;
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: begin
                if (i_stat.kind != KIND_FIND) begin
                    if (i_stat.out_free) n_state = ST_IDLE;
                end else if (!i_stat.in_map || i_stat.cnt_zero) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.cur_zero) begin
                    n_state = i_stat.word_last ? ST_DONE : ST_LOAD;
                end else if (i_stat.pos_over) begin
                    n_state = ST_DONE;
                end else if (!i_stat.pend_valid || i_stat.out_free) begin
                    if (i_stat.left_one) n_state = ST_DONE;
                end
            end
            ST_LOAD: n_state = ST_SCAN;
            ST_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLEAR: o_cmd.clr_step  = 1'b1;
            ST_IDLE:  o_cmd.accept    = i_in_valid;
            ST_QUOT:  o_cmd.calc_quot = 1'b1;
            ST_REM:   o_cmd.calc_rem  = 1'b1;
            ST_READ:  o_cmd.mem_rd    = 1'b1;
            ST_EXEC: begin
                if (i_stat.kind != KIND_FIND) begin
                    o_cmd.exec = i_stat.out_free;
                end else if (i_stat.in_map && !i_stat.cnt_zero) begin
                    o_cmd.find_start = 1'b1;
                end
            end
            ST_SCAN: begin
                if (i_stat.cur_zero) begin
                    o_cmd.scan_next = !i_stat.word_last;
                end else if (!i_stat.pos_over) begin
                    o_cmd.take = !i_stat.pend_valid || i_stat.out_free;
                end
            end
            ST_LOAD:  o_cmd.scan_load  = 1'b1;
            ST_DONE:  o_cmd.emit_final = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### hdl/bsc_dpath.sv
// ----------------------------------------------------------------------------
// bsc_dpath
// Bitmap memory, index decode, find walk registers and output register.
// ----------------------------------------------------------------------------
module bsc_dpath import bsc_pkg::*; #(
    parameter int MAP_BITS  = DEF_MAP_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int MAX_FOUND = DEF_MAX_FOUND
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_bit_index,
    input  logic [6:0]  i_max_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_found_index,
    output logic        o_hit,
    output logic        o_last
);

    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int PW        = $clog2(MAP_BITS + 2 * WORD_BITS);
    localparam int SHIFT     = 24;
    localparam int RECIP     = (1 << SHIFT) / WORD_BITS;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic [AW-1:0]        r_clr;
    t_kind                r_kind;
    logic [15:0]          r_idx;
    logic                 r_inside;
    logic [6:0]           r_left;
    logic [15:0]          r_q;
    logic [AW-1:0]        r_word;
    logic [BW-1:0]        r_bit;
    logic [PW-1:0]        r_base;
    logic [WORD_BITS-1:0] r_rd;
    logic [WORD_BITS-1:0] r_cur;
    logic                 r_pend_valid;
    logic [15:0]          r_pend_idx;
    logic                 r_out_valid;
    logic [15:0]          r_out_idx;
    logic                 r_out_hit;
    logic                 r_out_last;

    // index decode: reciprocal estimate, then one correction step
    logic [39:0]          qprod;
    logic [22:0]          qmul;
    logic [15:0]          rem_raw;
    logic                 rem_ge;
    logic [15:0]          q_fix;
    logic [15:0]          rem_fix;
    logic [15:0]          base_val;
    logic [AW+15:0]       q_ext;
    logic [PW+15:0]       base_ext;
    logic [PW+15:0]       idx_ext;

    assign qprod    = 40'(r_idx) * 40'(RECIP);
    assign qmul     = 23'(r_q) * 23'(WORD_BITS);
    assign rem_raw  = r_idx - qmul[15:0];
    assign rem_ge   = (rem_raw >= 16'(WORD_BITS));
    assign q_fix    = rem_ge ? r_q + 16'd1 : r_q;
    assign rem_fix  = rem_ge ? rem_raw - 16'(WORD_BITS) : rem_raw;
    assign base_val = r_idx - rem_fix;
    assign q_ext    = {{AW{1'b0}}, q_fix};
    assign base_ext = {{PW{1'b0}}, base_val};
    assign idx_ext  = {{PW{1'b0}}, i_bit_index};

    // find walk
    logic [5:0]           lsb;
    logic [PW-1:0]        pos;
    logic [PW+15:0]       pos_ext;
    logic                 cur_zero;
    logic                 pos_over;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 out_free;
    logic                 out_ld;

    assign lsb      = lowest_set(64'(r_cur));
    assign pos      = r_base + PW'(lsb);
    assign pos_ext  = {16'd0, pos};
    assign cur_zero = (r_cur == '0);
    assign pos_over = (pos >= PW'(MAP_BITS));
    assign bit_mask = WORD_BITS'(1) << r_bit;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_ld   = i_cmd.exec || (i_cmd.take && r_pend_valid) || i_cmd.emit_final;

    // memory write and read ports
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_word;
        wr_data = '0;
        if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
        end else if (i_cmd.exec && r_inside) begin
            if (r_kind == KIND_SET) begin
                wr_en   = 1'b1;
                wr_data = r_rd | bit_mask;
            end else if (r_kind == KIND_CLEAR) begin
                wr_en   = 1'b1;
                wr_data = r_rd & ~bit_mask;
            end
        end
    end

    assign rd_en   = i_cmd.mem_rd || i_cmd.scan_next;
    assign rd_addr = i_cmd.scan_next ? r_word + AW'(1) : r_word;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + AW'(1);
            if (i_cmd.accept) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.take) begin
                r_pend_valid <= 1'b1;
            end
            if (out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind   <= t_kind'(i_kind);
            r_idx    <= i_bit_index;
            r_inside <= (idx_ext < (PW+16)'(MAP_BITS));
            r_left   <= (i_max_count > 7'(MAX_FOUND)) ? 7'(MAX_FOUND) : i_max_count;
        end
        if (i_cmd.calc_quot) r_q <= qprod[SHIFT+15:SHIFT];
        if (i_cmd.calc_rem) begin
            r_word <= q_ext[AW-1:0];
            r_bit  <= rem_fix[BW-1:0];
            r_base <= base_ext[PW-1:0];
        end
        if (i_cmd.find_start) r_cur <= r_rd & ({WORD_BITS{1'b1}} << r_bit);
        if (i_cmd.scan_next) begin
            r_word <= r_word + AW'(1);
            r_base <= r_base + PW'(WORD_BITS);
        end
        if (i_cmd.scan_load) r_cur <= r_rd;
        if (i_cmd.take) begin
            r_cur      <= r_cur & (r_cur - WORD_BITS'(1));
            r_left     <= r_left - 7'd1;
            r_pend_idx <= pos_ext[15:0];
        end
        if (i_cmd.exec) begin
            r_out_idx  <= 16'd0;
            r_out_hit  <= (r_kind == KIND_TEST) ? (r_inside && r_rd[r_bit]) : 1'b1;
            r_out_last <= 1'b1;
        end else if (i_cmd.take && r_pend_valid) begin
            r_out_idx  <= r_pend_idx;
            r_out_hit  <= 1'b1;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out_idx  <= r_pend_valid ? r_pend_idx : 16'd0;
            r_out_hit  <= r_pend_valid;
            r_out_last <= 1'b1;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.clr_last   = (r_clr == AW'(NUM_WORDS - 1));
        o_stat.kind       = r_kind;
        o_stat.in_map     = r_inside;
        o_stat.cnt_zero   = (r_left == 7'd0);
        o_stat.cur_zero   = cur_zero;
        o_stat.word_last  = (r_word == AW'(NUM_WORDS - 1));
        o_stat.pos_over   = pos_over;
        o_stat.pend_valid = r_pend_valid;
        o_stat.left_one   = (r_left == 7'd1);
        o_stat.out_free   = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_found_index = r_out_idx;
    assign o_hit         = r_out_hit;
    assign o_last        = r_out_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ld |-> out_free)
        else $error("result loaded over a held result");

    a_pend_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_left < 7'(MAX_FOUND)))
        else $error("pending index without a consumed count");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> (!cur_zero && !pos_over))
        else $error("take without a set bit inside the map");

    a_wr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |=> !wr_en)
        else $error("memory written during find walk");

endmodule

### hdl/bitmap_set_clear_find_engine_core.sv
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_engine_core
// Flat bitmap with set, clear, test and find-next-set-bits requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request item: kind,
//   bit_index and max_count. Output channel (o_out_valid / i_out_stall)
//   carries result items: found_index, hit and last.
//   Set, clear and test give one result each; the item is accepted, the
//   index is split into word and bit (quotient, then remainder), the word
//   is read, written back for set and clear, and the result is registered;
//   the next item is taken only once the sequencer is back in idle.
//   Find takes the same setup steps, then walks the set bits word by word;
//   an empty word is skipped by a read and a load step (one memory read port,
//   registered read data), and a final result closes the walk. Results leave
//   in ascending order and the final one has last set; a find with nothing
//   to report gives one result with hit low.
//   After reset the bitmap memory is cleared one word a cycle; the input
//   stays stalled until the last word has been cleared.
//   When the receiver stalls, the output register holds its result; a new
//   request is still accepted and runs until it needs to emit.
// ----------------------------------------------------------------------------
module bitmap_set_clear_find_engine_core import bsc_pkg::*; #(
    parameter int MAP_BITS  = DEF_MAP_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int MAX_FOUND = DEF_MAX_FOUND
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_bit_index,
    input  logic [6:0]  i_max_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_found_index,
    output logic        o_hit,
    output logic        o_last
);

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: clear pass, decode, access, walk and emit steps
    bsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: bitmap memory, walk registers and output register
    bsc_dpath #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS),
        .MAX_FOUND (MAX_FOUND)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_bit_index   (i_bit_index),
        .i_max_count   (i_max_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found_index (o_found_index),
        .o_hit         (o_hit),
        .o_last        (o_last)
    );

endmodule
